// ===== rtl/hrc_pkg.sv =====
// ----------------------------------------------------------------------------
// hrc_pkg
// Shared types and constants for the HSL rainbow color generator.
// ----------------------------------------------------------------------------
package hrc_pkg;

  // Default widths of the time base and the color channels
  localparam int TIME_WIDTH_DEF    = 32;
  localparam int CHANNEL_WIDTH_DEF = 16;

  // Fixed port widths
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int DELAY_W    = 16;
  localparam int OUT_W      = 16;

  // Color channels, in lane order: red, green, blue
  localparam int NUM_CH = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SATURATION   = 2'd0,
    REG_LIGHTNESS    = 2'd1,
    REG_HUE_STEP     = 2'd2,
    REG_UPDATE_DELAY = 2'd3
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LS_WAIT,
    ST_QCALC,
    ST_PCALC,
    ST_CH_SETUP,
    ST_CH_WAIT,
    ST_EMIT
  } state_t;

  // Segment of the hue circle a channel falls in
  typedef enum logic [1:0] {
    RG_RISE,
    RG_HIGH,
    RG_FALL,
    RG_LOW
  } region_t;

endpackage

// ===== rtl/hrc_serial_mul.sv =====
// ----------------------------------------------------------------------------
// hrc_serial_mul
// Bit-serial shift-add multiplier returning the upper half of a W x W product.
// ----------------------------------------------------------------------------
module hrc_serial_mul #(
  parameter int W = hrc_pkg::CHANNEL_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] mcand,
  input  logic [W-1:0] mplier,
  output logic         done,
  output logic [W-1:0] prod
);

  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     mcand_r, mcand_nxt;
  logic [W-1:0]     mplier_r, mplier_nxt;
  logic [W-1:0]     acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [W:0]       sum;

  // One multiplier bit per cycle, LSB first; low product bits fall off the end
  always_comb begin
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    acc_nxt    = acc_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    sum        = {1'b0, acc_r} + (mplier_r[0] ? {1'b0, mcand_r} : '0);
    if (start) begin
      mcand_nxt  = mcand;
      mplier_nxt = mplier;
      acc_nxt    = '0;
      cnt_nxt    = CNT_W'(W);
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      acc_nxt    = sum[W:1];
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operands and accumulator
  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
    acc_r    <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== rtl/hsl_rainbow_color_generator.sv =====
// ----------------------------------------------------------------------------
// hsl_rainbow_color_generator
// Timed hue sweep: converts the stored hue with configured S and L to RGB.
// ----------------------------------------------------------------------------
// An updating tick runs two bit-serial multiplier passes, l*s and then the
//   channel ramps, before its color shows; zero saturation skips both.
// A tick before its deadline returns to idle with no color. No new tick is
//   taken until the current one is done.
// A stalled output holds the sequencer in its final state.
// Reset (synchronous): config to defaults, hue and deadline to zero.
module hsl_rainbow_color_generator #(
  parameter int TIME_WIDTH    = hrc_pkg::TIME_WIDTH_DEF,
  parameter int CHANNEL_WIDTH = hrc_pkg::CHANNEL_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [TIME_WIDTH-1:0]          in_current_time,
  input  logic                           in_restart,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [hrc_pkg::OUT_W-1:0]      out_red,
  output logic [hrc_pkg::OUT_W-1:0]      out_green,
  output logic [hrc_pkg::OUT_W-1:0]      out_blue,
  input  logic                           cfg_we,
  input  logic [hrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hrc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW    = CHANNEL_WIDTH;
  localparam int TW    = TIME_WIDTH;
  localparam int NCH   = hrc_pkg::NUM_CH;
  localparam int OW    = hrc_pkg::OUT_W;
  localparam int DW    = hrc_pkg::DELAY_W;
  localparam int SUM_W = ((TW > DW) ? TW : DW) + 1;

  // Fixed-point fractions of one turn
  localparam logic [CW-1:0] CMAX_C       = {CW{1'b1}};
  localparam logic [CW-1:0] HALF_C       = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] THIRD_C      = CW'((64'd1 << CW) / 64'd3);
  localparam logic [CW-1:0] SIXTH_C      = CW'((64'd1 << CW) / 64'd6);
  localparam logic [CW-1:0] TWO_THIRDS_C = CW'((64'd2 << CW) / 64'd3);
  localparam logic [CW-1:0] STEP_RST_C   = CW'((64'd1 << CW) / 64'd100);

  // Configuration registers
  logic [CW-1:0] sat_r, light_r, step_r;
  logic [DW-1:0] delay_r;

  // Sequencer and state
  hrc_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]    hue_r, hue_nxt;
  logic [TW-1:0]    deadline_r, deadline_nxt;
  logic [TW-1:0]    now_r, now_nxt;
  logic             restart_r, restart_nxt;
  logic [CW-1:0]    ls_r, ls_nxt;
  logic [CW-1:0]    q_r, q_nxt;
  logic [CW-1:0]    p_r, p_nxt;
  hrc_pkg::region_t region_r [NCH];
  hrc_pkg::region_t region_nxt [NCH];
  logic [CW-1:0]    rgb_r [NCH];
  logic [CW-1:0]    rgb_nxt [NCH];
  logic             out_valid_r, out_valid_nxt;
  logic [OW-1:0]    out_rgb_r [NCH];
  logic [OW-1:0]    out_rgb_nxt [NCH];

  // Datapath helpers
  logic [CW:0]      q_sum, two_l, p_dif;
  logic [CW-1:0]    q_c, p_c, diff_c;
  logic [CW-1:0]    t_c [NCH];
  logic [CW-1:0]    x_c [NCH];
  logic [CW+1:0]    x6_c [NCH];
  logic [CW-1:0]    mult_c [NCH];
  hrc_pkg::region_t region_c [NCH];
  logic [CW:0]      v_sum [NCH];
  logic [CW-1:0]    val_c [NCH];
  logic [SUM_W-1:0] dl_sum;
  logic [TW-1:0]    dl_c;

  // Multiplier lanes
  logic             mul_start;
  logic [CW-1:0]    mul_a [NCH];
  logic [CW-1:0]    mul_b [NCH];
  logic [NCH-1:0]   mul_done;
  logic [CW-1:0]    mul_prod [NCH];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r   <= CMAX_C;
      light_r <= HALF_C;
      step_r  <= STEP_RST_C;
      delay_r <= DW'(1);
    end else if (cfg_we) begin
      unique case (hrc_pkg::cfg_reg_t'(cfg_index))
        hrc_pkg::REG_SATURATION:   sat_r   <= CW'(cfg_wdata);
        hrc_pkg::REG_LIGHTNESS:    light_r <= CW'(cfg_wdata);
        hrc_pkg::REG_HUE_STEP:     step_r  <= CW'(cfg_wdata);
        hrc_pkg::REG_UPDATE_DELAY: delay_r <= cfg_wdata;
      endcase
    end
  end

  // q and p of the HSL conversion, and the swing between them
  always_comb begin
    if (light_r < HALF_C) begin
      q_sum = {1'b0, light_r} + {1'b0, ls_r};
    end else begin
      q_sum = {1'b0, light_r} + {1'b0, sat_r} - {1'b0, ls_r};
    end
    q_c   = q_sum[CW] ? CMAX_C : q_sum[CW-1:0];
    two_l = {light_r, 1'b0};
    p_dif = two_l - {1'b0, q_r};
    if (two_l > {1'b0, q_r}) begin
      p_c = p_dif[CW] ? CMAX_C : p_dif[CW-1:0];
    end else begin
      p_c = '0;
    end
    diff_c = q_r - p_r;
  end

  // Per-channel hue, segment and ramp multiplier
  always_comb begin
    t_c[0] = hue_r + THIRD_C;
    t_c[1] = hue_r;
    t_c[2] = hue_r - THIRD_C;
    for (int ch = 0; ch < NCH; ch++) begin
      if (t_c[ch] < SIXTH_C) begin
        region_c[ch] = hrc_pkg::RG_RISE;
        x_c[ch]      = t_c[ch];
      end else if (t_c[ch] < HALF_C) begin
        region_c[ch] = hrc_pkg::RG_HIGH;
        x_c[ch]      = '0;
      end else if (t_c[ch] < TWO_THIRDS_C) begin
        region_c[ch] = hrc_pkg::RG_FALL;
        x_c[ch]      = TWO_THIRDS_C - t_c[ch];
      end else begin
        region_c[ch] = hrc_pkg::RG_LOW;
        x_c[ch]      = '0;
      end
      // 6*x stays below one turn since x never exceeds one sixth
      x6_c[ch]   = {x_c[ch], 2'b00} + {1'b0, x_c[ch], 1'b0};
      mult_c[ch] = x6_c[ch][CW-1:0];
    end
  end

  // Channel values from the ramp products
  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      v_sum[ch] = {1'b0, p_r} + {1'b0, mul_prod[ch]};
      case (region_r[ch]) inside
        hrc_pkg::RG_RISE, hrc_pkg::RG_FALL: val_c[ch] = v_sum[ch][CW] ? CMAX_C : v_sum[ch][CW-1:0];
        hrc_pkg::RG_HIGH: val_c[ch] = q_r;
        default:          val_c[ch] = p_r;
      endcase
    end
  end

  // Next deadline, saturating at the top of the time range
  always_comb begin
    dl_sum = SUM_W'(now_r) + SUM_W'(delay_r);
    dl_c   = (|(dl_sum >> TW)) ? {TW{1'b1}} : dl_sum[TW-1:0];
  end

  // Lane operands: lane 0 forms l*s first, then all lanes run the ramps
  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      mul_a[ch] = diff_c;
      mul_b[ch] = mult_c[ch];
    end
    if (state_r == hrc_pkg::ST_CHECK) begin
      mul_a[0] = light_r;
      mul_b[0] = sat_r;
    end
  end

  for (genvar ch = 0; ch < NCH; ch++) begin : g_lane
    hrc_serial_mul #(
      .W(CW)
    ) u_mul (
      .clk    (clk),
      .rst_n  (rst_n),
      .start  (mul_start),
      .mcand  (mul_a[ch]),
      .mplier (mul_b[ch]),
      .done   (mul_done[ch]),
      .prod   (mul_prod[ch])
    );
  end

  // Sequencer: next state and outputs
  always_comb begin
    state_nxt     = state_r;
    now_nxt       = now_r;
    restart_nxt   = restart_r;
    hue_nxt       = hue_r;
    deadline_nxt  = deadline_r;
    ls_nxt        = ls_r;
    q_nxt         = q_r;
    p_nxt         = p_r;
    region_nxt    = region_r;
    rgb_nxt       = rgb_r;
    out_rgb_nxt   = out_rgb_r;
    out_valid_nxt = out_valid_r && out_stall;
    mul_start     = 1'b0;
    in_stall      = (state_r != hrc_pkg::ST_IDLE);

    unique case (state_r)
      hrc_pkg::ST_IDLE: begin
        if (in_valid) begin
          now_nxt     = in_current_time;
          restart_nxt = in_restart;
          state_nxt   = hrc_pkg::ST_CHECK;
        end
      end
      hrc_pkg::ST_CHECK: begin
        // restart bypasses the deadline check, so the tick always updates
        if (restart_r || (now_r >= deadline_r)) begin
          if (sat_r == '0) begin
            for (int ch = 0; ch < NCH; ch++) begin
              rgb_nxt[ch] = light_r;
            end
            state_nxt = hrc_pkg::ST_EMIT;
          end else begin
            mul_start = 1'b1;
            state_nxt = hrc_pkg::ST_LS_WAIT;
          end
        end else begin
          state_nxt = hrc_pkg::ST_IDLE;
        end
      end
      hrc_pkg::ST_LS_WAIT: begin
        if (&mul_done) begin
          ls_nxt    = mul_prod[0];
          state_nxt = hrc_pkg::ST_QCALC;
        end
      end
      hrc_pkg::ST_QCALC: begin
        q_nxt     = q_c;
        state_nxt = hrc_pkg::ST_PCALC;
      end
      hrc_pkg::ST_PCALC: begin
        p_nxt     = p_c;
        state_nxt = hrc_pkg::ST_CH_SETUP;
      end
      hrc_pkg::ST_CH_SETUP: begin
        mul_start  = 1'b1;
        region_nxt = region_c;
        state_nxt  = hrc_pkg::ST_CH_WAIT;
      end
      hrc_pkg::ST_CH_WAIT: begin
        if (&mul_done) begin
          rgb_nxt   = val_c;
          state_nxt = hrc_pkg::ST_EMIT;
        end
      end
      hrc_pkg::ST_EMIT: begin
        // hand off once the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          for (int ch = 0; ch < NCH; ch++) begin
            out_rgb_nxt[ch] = OW'(rgb_r[ch]);
          end
          hue_nxt      = hue_r + step_r;
          deadline_nxt = dl_c;
          state_nxt    = hrc_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hrc_pkg::ST_IDLE;
      hue_r       <= '0;
      deadline_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hue_r       <= hue_nxt;
      deadline_r  <= deadline_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    now_r     <= now_nxt;
    restart_r <= restart_nxt;
    ls_r      <= ls_nxt;
    q_r       <= q_nxt;
    p_r       <= p_nxt;
    region_r  <= region_nxt;
    rgb_r     <= rgb_nxt;
    out_rgb_r <= out_rgb_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_rgb_r[0];
  assign out_green = out_rgb_r[1];
  assign out_blue  = out_rgb_r[2];

endmodule

// ===== rtl/hrc_checker.sv =====
// ----------------------------------------------------------------------------
// hrc_checker
// Port-level checks for the HSL rainbow color generator, bound to the top.
// ----------------------------------------------------------------------------
module hrc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [hrc_pkg::OUT_W-1:0] out_red,
  input logic [hrc_pkg::OUT_W-1:0] out_green,
  input logic [hrc_pkg::OUT_W-1:0] out_blue
);

  // A stalled result transaction keeps its color
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue))
    else $error("stalled result changed or dropped");

  // One tick at a time: busy right after an accepted tick
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after accepted transaction");

  // Reset empties the output register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A new result only comes out of a tick in progress
  a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a tick in progress");

endmodule

bind hsl_rainbow_color_generator hrc_checker u_hrc_checker (.*);

// ===== dv/tb_hsl_rainbow_color_generator.sv =====
// ----------------------------------------------------------------------------
// tb_hsl_rainbow_color_generator
// Self-checking bench for the timed HSL-to-RGB hue sweep. A directed table
// covers reset colors, grey at zero saturation, lightness extremes, restart,
// deadline saturation, backward time and hue wrap. Random phases follow,
// each with its own register setting. Every accepted tick runs through an
// in-bench color predictor, and each output transaction is checked against
// the oldest pending color. Sender bursts and receiver stalls vary at random.
// ----------------------------------------------------------------------------
module tb_hsl_rainbow_color_generator;

  localparam int CLK_PERIOD    = 8;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 48;
  localparam int RUN_LIMIT     = 800000;
  localparam int NUM_PHASES    = 7;
  localparam int PHASE_TICKS   = 200;

  // 0.16 fixed-point constants
  localparam logic [63:0] ONE_Q        = 64'h10000;
  localparam logic [63:0] CMAX_Q       = 64'hFFFF;
  localparam logic [63:0] HALF_Q       = 64'h8000;
  localparam logic [63:0] THIRD_Q      = 64'd21845;
  localparam logic [63:0] SIXTH_Q      = 64'd10922;
  localparam logic [63:0] TWO_THIRDS_Q = 64'd43690;

  typedef struct packed {
    logic [hrc_pkg::OUT_W-1:0] red;
    logic [hrc_pkg::OUT_W-1:0] green;
    logic [hrc_pkg::OUT_W-1:0] blue;
  } rgb_t;

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    hrc_pkg::cfg_reg_t cfg_sel;
    logic [15:0]       cfg_val;
    logic [31:0]       tm;
    logic              rs;
    logic              typed;
    rgb_t              want;
  } dir_row_t;

  localparam int NUM_DIR_ROWS = 31;

  // Directed table: typed colors only where they follow at a glance
  localparam dir_row_t DIR_ROWS [NUM_DIR_ROWS] = '{
    // reset state: hue 0 at full saturation, half lightness
    '{ROW_TICK, hrc_pkg::REG_SATURATION, 16'h0, 32'h0, 1'b0, 1'b1,
      '{16'hFFFF, 16'h0001, 16'h0001}},
    '{ROW_TICK, hrc_pkg::REG_SATURATION, 16'h0, 32'h0, 1'b0, 1'b0, '0},
    '{ROW_TICK, hrc_pkg::REG_SATURATION, 16'h0, 32'h1, 1'b0, 1'b0, '0},
    '{ROW_TICK, hrc_pkg::REG_SATURATION, 16'h0, 32'h1, 1'b1, 1'b0, '0},
    // grey at zero saturation
    '{ROW_CFG, hrc_pkg::REG_SATURATION, 16'h0000, 32'h0, 1'b0, 1'b0, '0},
    '{ROW_CFG, hrc_pkg::REG_LIGHTNESS, 16'h1234, 32'h0, 1'b0, 1'b0, '0},
    '{ROW_TICK, hrc_pkg::REG_SATURATION, 16'h0, 32'h5, 1'b1, 1'b1,
      '{16'h1234, 16'h1234, 16'h1234}},
    // deadline saturates at the top of the time range
    '{ROW_TICK, hrc_pkg::REG_SATURATION, 16'h0, 32'hFFFF_FFFF, 1'b0, 1'b1,
      '{16'h1234, 16'h1234, 16'h1234}},
    '{ROW_TICK, hrc_pkg::REG_SATURATION, 16'h0, 32'hFFFF_FFFF, 1'b0, 1'b1,
      '{16'h1234, 16'h1234, 16'h1234}},
    // time going backwards, then restart
    '{ROW_TICK, hrc_pkg::REG_SATURATION, 16'h0, 32'd100, 1'b0, 1'b0, '0},
    '{ROW_TICK, hrc_pkg::REG_SATURATION, 16'h0, 32'd200, 1'b1, 1'b1,
      '{16'h1234, 16'h1234, 16'h1234}},
    // lightness extremes
    '{ROW_CFG, hrc_pkg::REG_LIGHTNESS, 16'h0000, 32'h0, 1'b0, 1'b0, '0},
    '{ROW_TICK, hrc_pkg::REG_SATURATION, 16'h0, 32'd300, 1'b1, 1'b1,
      '{16'h0000, 16'h0000, 16'h0000}},
    '{ROW_CFG, hrc_pkg::REG_LIGHTNESS, 16'hFFFF, 32'h0, 1'b0, 1'b0, '0},
    '{ROW_TICK, hrc_pkg::REG_SATURATION, 16'h0, 32'd300, 1'b1, 1'b1,
      '{16'hFFFF, 16'hFFFF, 16'hFFFF}},
    '{ROW_CFG, hrc_pkg::REG_SATURATION, 16'hFFFF, 32'h0, 1'b0, 1'b0, '0},
    '{ROW_TICK, hrc_pkg::REG_SATURATION, 16'h0, 32'd300, 1'b1, 1'b1,
      '{16'hFFFF, 16'hFFFF, 16'hFFFF}},
    '{ROW_CFG, hrc_pkg::REG_LIGHTNESS, 16'h0000, 32'h0, 1'b0, 1'b0, '0},
    '{ROW_TICK, hrc_pkg::REG_SATURATION, 16'h0, 32'd300, 1'b1, 1'b1,
      '{16'h0000, 16'h0000, 16'h0000}},
    // zero delay with a full-turn-minus-one step: every tick fires, hue wraps
    '{ROW_CFG, hrc_pkg::REG_LIGHTNESS, 16'h8000, 32'h0, 1'b0, 1'b0, '0},
    '{ROW_CFG, hrc_pkg::REG_HUE_STEP, 16'hFFFF, 32'h0, 1'b0, 1'b0, '0},
    '{ROW_CFG, hrc_pkg::REG_UPDATE_DELAY, 16'h0000, 32'h0, 1'b0, 1'b0, '0},
    '{ROW_TICK, hrc_pkg::REG_SATURATION, 16'h0, 32'd400, 1'b0, 1'b0, '0},
    '{ROW_TICK, hrc_pkg::REG_SATURATION, 16'h0, 32'd400, 1'b0, 1'b0, '0},
    '{ROW_TICK, hrc_pkg::REG_SATURATION, 16'h0, 32'd400, 1'b0, 1'b0, '0},
    // half-turn step, longest delay: fire exactly at the deadline
    '{ROW_CFG, hrc_pkg::REG_HUE_STEP, 16'h8000, 32'h0, 1'b0, 1'b0, '0},
    '{ROW_CFG, hrc_pkg::REG_UPDATE_DELAY, 16'hFFFF, 32'h0, 1'b0, 1'b0, '0},
    '{ROW_TICK, hrc_pkg::REG_SATURATION, 16'h0, 32'd500, 1'b0, 1'b0, '0},
    '{ROW_TICK, hrc_pkg::REG_SATURATION, 16'h0, 32'h0001_01F2, 1'b0, 1'b0, '0},
    '{ROW_TICK, hrc_pkg::REG_SATURATION, 16'h0, 32'h0001_01F3, 1'b0, 1'b0, '0},
    '{ROW_TICK, hrc_pkg::REG_SATURATION, 16'h0, 32'h0001_01F4, 1'b0, 1'b0, '0}
  };

  logic                           clk;
  logic                           rst_n           = 1'b0;
  logic                           in_valid        = 1'b0;
  logic                           in_stall;
  logic [31:0]                    in_current_time = '0;
  logic                           in_restart      = 1'b0;
  logic                           out_valid;
  logic                           out_stall       = 1'b0;
  logic [hrc_pkg::OUT_W-1:0]      out_red;
  logic [hrc_pkg::OUT_W-1:0]      out_green;
  logic [hrc_pkg::OUT_W-1:0]      out_blue;
  logic                           cfg_we          = 1'b0;
  logic [hrc_pkg::CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [hrc_pkg::CFG_DATA_W-1:0] cfg_wdata       = '0;

  // Shadow registers and sweep state, reset values
  logic [15:0] sat_q      = 16'hFFFF;
  logic [15:0] light_q    = 16'h8000;
  logic [15:0] step_q     = 16'd655;
  logic [15:0] delay_q    = 16'd1;
  logic [15:0] hue_q      = '0;
  logic [31:0] deadline_q = '0;

  rgb_t pending_colors [$];
  int   err_count;
  int   stall_age;
  int   stall_mode;

  hsl_rainbow_color_generator DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_current_time (in_current_time),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT * CLK_PERIOD);
    $display("CHECK FAILED");
    $finish;
  end

  // Color predictor
  function automatic logic [15:0] clamp_chan(input logic [63:0] v);
    return (v > CMAX_Q) ? 16'hFFFF : v[15:0];
  endfunction

  // Level of one channel at hue position pos between floor lo and peak hi
  function automatic logic [15:0] ramp_level(input logic [63:0] lo, hi, pos);
    logic [63:0] span;
    span = hi - lo;
    if (pos < SIXTH_Q) return clamp_chan(lo + ((span * 64'd6 * pos) >> 16));
    if (pos < HALF_Q) return clamp_chan(hi);
    if (pos < TWO_THIRDS_Q)
      return clamp_chan(lo + ((span * (TWO_THIRDS_Q - pos) * 64'd6) >> 16));
    return clamp_chan(lo);
  endfunction

  function automatic rgb_t hsl_color(input logic [15:0] h, s, l);
    logic [63:0] h64, s64, l64, ls, q, p;
    rgb_t col;
    if (s == '0) return '{red: l, green: l, blue: l};
    h64 = {48'd0, h};
    s64 = {48'd0, s};
    l64 = {48'd0, l};
    ls  = (l64 * s64) >> 16;
    q   = (l64 < HALF_Q) ? l64 + ls : l64 + s64 - ls;
    if (q > CMAX_Q) q = CMAX_Q;
    p   = (2 * l64 > q) ? 2 * l64 - q : 64'd0;
    if (p > CMAX_Q) p = CMAX_Q;
    col.red   = ramp_level(p, q, (h64 + THIRD_Q) & CMAX_Q);
    col.green = ramp_level(p, q, h64);
    col.blue  = ramp_level(p, q, (h64 + ONE_Q - THIRD_Q) & CMAX_Q);
    return col;
  endfunction

  // Applies one tick to the sweep state; returns 1 when it emits a color
  function automatic bit advance_tick(input logic [31:0] now, input logic rs,
                                      output rgb_t col);
    logic [32:0] due;
    col = '0;
    if (rs) deadline_q = '0;
    if (now < deadline_q) return 1'b0;
    col        = hsl_color(hue_q, sat_q, light_q);
    hue_q      = hue_q + step_q;
    due        = {1'b0, now} + {17'd0, delay_q};
    deadline_q = due[32] ? 32'hFFFF_FFFF : due[31:0];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  // Drive one tick and hold it until the block takes it
  task automatic send_tick(input logic [31:0] tm, input logic rs,
                           input logic typed, input rgb_t typed_col);
    rgb_t col;
    in_valid        <= 1'b1;
    in_current_time <= tm;
    in_restart      <= rs;
    do @(posedge clk); while (in_stall);
    if (advance_tick(tm, rs, col)) pending_colors.push_back(typed ? typed_col : col);
  endtask

  // Wait for all colors, then let a tick with no result finish
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write per call; the caller drops cfg_we after the batch
  task automatic write_reg(input hrc_pkg::cfg_reg_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      hrc_pkg::REG_SATURATION: sat_q   = val;
      hrc_pkg::REG_LIGHTNESS:  light_q = val;
      hrc_pkg::REG_HUE_STEP:   step_q  = val;
      default:                 delay_q = val;
    endcase
  endtask

  // Result check and receiver stall pattern
  always @(posedge clk) begin : result_check
    rgb_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_colors.size() == 0) begin
        report_mismatch($sformatf("unexpected color %h %h %h",
                                  out_red, out_green, out_blue));
      end else begin
        want = pending_colors.pop_front();
        if (out_red !== want.red)
          report_mismatch($sformatf("red got %h want %h", out_red, want.red));
        if (out_green !== want.green)
          report_mismatch($sformatf("green got %h want %h", out_green, want.green));
        if (out_blue !== want.blue)
          report_mismatch($sformatf("blue got %h want %h", out_blue, want.blue));
      end
    end
    // stall mode is redrawn at random whenever stall_age wraps to zero
    if (stall_age == 0) stall_mode = $urandom_range(0, 3);
    stall_age = (stall_age + 1) % 300;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_age % 7) < 3);
    endcase
  end

  // Stimulus
  initial begin
    logic [31:0] cur_time;
    logic [15:0] sat_v, light_v, step_v, delay_v;
    logic        rs;
    int          sel, burst_left, gap;

    err_count  = 0;
    burst_left = 0;
    cur_time   = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed table
    for (int i = 0; i < NUM_DIR_ROWS; i++) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        if (!cfg_we) drain_and_settle();
        write_reg(DIR_ROWS[i].cfg_sel, DIR_ROWS[i].cfg_val);
      end else begin
        if (cfg_we) cfg_we <= 1'b0;
        send_tick(DIR_ROWS[i].tm, DIR_ROWS[i].rs, DIR_ROWS[i].typed, DIR_ROWS[i].want);
      end
    end

    // random phases, each with its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          sat_v = 16'hFFFF; light_v = 16'h8000; step_v = 16'd655; delay_v = 16'd1;
        end
        1: begin
          sat_v = 16'h0000; light_v = 16'($urandom); step_v = 16'($urandom);
          delay_v = 16'd0;
        end
        2: begin
          sat_v = 16'hFFFF; light_v = 16'hFFFF; step_v = 16'hFFFF; delay_v = 16'hFFFF;
        end
        3: begin
          sat_v = 16'h0001; light_v = 16'h0000; step_v = 16'h0001; delay_v = 16'd2;
        end
        4: begin
          sat_v = 16'hFFFF; light_v = 16'h7FFF; step_v = 16'($urandom);
          delay_v = 16'($urandom_range(0, 8));
        end
        default: begin
          sat_v = 16'($urandom); light_v = 16'($urandom); step_v = 16'($urandom);
          delay_v = 16'($urandom_range(0, 40));
        end
      endcase
      drain_and_settle();
      write_reg(hrc_pkg::REG_SATURATION, sat_v);
      write_reg(hrc_pkg::REG_LIGHTNESS, light_v);
      write_reg(hrc_pkg::REG_HUE_STEP, step_v);
      write_reg(hrc_pkg::REG_UPDATE_DELAY, delay_v);
      cfg_we <= 1'b0;

      for (int k = 0; k < PHASE_TICKS; k++) begin
        // mostly forward time, some restarts, jumps and backward steps
        sel = $urandom_range(0, 99);
        rs  = 1'b0;
        if (sel < 8) begin
          rs = 1'b1;
        end else if (sel < 11) begin
          cur_time = $urandom;
        end else if (sel < 13) begin
          cur_time = 32'hFFFF_FFFF - $urandom_range(0, 2 * int'(delay_v) + 1);
        end else if (sel < 16) begin
          cur_time = cur_time - $urandom_range(0, 2 * int'(delay_v) + 1);
        end else begin
          cur_time = cur_time + $urandom_range(0, 2 * int'(delay_v) + 1);
        end
        send_tick(cur_time, rs, 1'b0, '0);

        // bursts with random gaps between them
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end else begin
          burst_left--;
        end
      end
    end

    drain_and_settle();
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== hsl_rainbow_color_generator.f =====
rtl/hrc_pkg.sv
rtl/hrc_serial_mul.sv
rtl/hsl_rainbow_color_generator.sv
rtl/hrc_checker.sv
dv/tb_hsl_rainbow_color_generator.sv
